// ===== rtl/core/bfvs_pkg.sv =====
// ============================================================================
// bfvs_pkg
// Shared types, constants and helpers of the bus frame video switch block.
// ============================================================================
`default_nettype none

package bfvs_pkg;

    // Storage sizing
    localparam int BUF_DEPTH    = 32;
    localparam int CUSTOM_BYTES = 12;
    localparam int NPAIR        = CUSTOM_BYTES / 2;
    localparam int POS_W        = $clog2(BUF_DEPTH + 1);
    localparam int ADDR_W       = $clog2(BUF_DEPTH);
    localparam int PAIR_W       = (NPAIR > 1) ? $clog2(NPAIR) : 1;
    localparam int SHADOW_N     = 25;
    localparam int SH_W         = $clog2(SHADOW_N);
    localparam logic [7:0] IDX_LIMIT = 8'(BUF_DEPTH);

    // Pin bit positions
    localparam int PIN_RELAY  = 0;
    localparam int PIN_TRIG   = 1;
    localparam int PIN_PWROFF = 2;
    localparam int PIN_HB     = 3;

    // Settings bit positions
    localparam int SET_NO_PHONE  = 0;
    localparam int SET_NO_CAMERA = 1;
    localparam int SET_NO_CDC    = 2;
    localparam int SET_NO_IDLE   = 3;

    // Timing in ticks
    localparam logic [8:0]  IDLE_LIMIT   = 9'd360;
    localparam logic [9:0]  HB_IDLE_WRAP = 10'd750;
    localparam logic [9:0]  HB_SECOND    = 10'd150;
    localparam logic [10:0] BOOT_TICKS   = 11'd1350;
    localparam logic [10:0] BOOT_WINDOW  = 11'd900;
    localparam logic [9:0]  LED_T_BOOT   = 10'd450;
    localparam logic [9:0]  LED_T_FOB    = 10'd750;
    localparam logic [9:0]  LED_T_PHONE  = 10'd75;

    // LED patterns
    localparam logic [5:0] LED_SRC0 = 6'h01;
    localparam logic [5:0] LED_SRC1 = 6'h10;
    localparam logic [5:0] LED_SRC2 = 6'h04;
    localparam logic [5:0] LED_ALL  = 6'h3F;

    // Frame actions
    localparam logic [3:0] ACT_NONE   = 4'd0;
    localparam logic [3:0] ACT_PHONE  = 4'd1;
    localparam logic [3:0] ACT_FOB    = 4'd2;
    localparam logic [3:0] ACT_CAMERA = 4'd3;
    localparam logic [3:0] ACT_SETWR  = 4'd4;
    localparam logic [3:0] ACT_ENTER  = 4'd5;
    localparam logic [3:0] ACT_LEAVE  = 4'd6;
    localparam logic [3:0] ACT_CUSTOM = 4'd7;

    typedef struct packed {
        logic accept;
        logic judge;
        logic ck_cmp;
        logic ck_enter;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic complete;
        logic custom;
        logic pair_match;
        logic pair_last;
        logic out_free;
    } ctl_status_t;

    function automatic logic [3:0] drive_source(input logic [3:0] pins, input logic [7:0] s);
        logic [3:0] p;
        p = pins;
        if (s == 8'd0)
        begin
            p[PIN_RELAY] = 1'b0;
            p[PIN_TRIG]  = 1'b0;
        end
        else if (s == 8'd1)
        begin
            p[PIN_PWROFF] = 1'b0;
            p[PIN_RELAY]  = 1'b0;
            p[PIN_TRIG]   = 1'b1;
        end
        else if (s == 8'd2)
        begin
            p[PIN_RELAY] = 1'b1;
            p[PIN_TRIG]  = 1'b1;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfvs_if.sv =====
// ============================================================================
// bfvs_if
// Valid/ready channels for input items and result items.
// ============================================================================
`default_nettype none

interface bfvs_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;
    logic       rx_error;
    logic       line_idle;

    modport source (output valid, cmd, rx_byte, rx_error, line_idle, input ready);
    modport sink   (input valid, cmd, rx_byte, rx_error, line_idle, output ready);
endinterface

interface bfvs_out_if;
    logic       valid;
    logic       ready;
    logic       relay_video_on;
    logic       video_trigger;
    logic       pi_power_off;
    logic       heartbeat_led;
    logic       leds_off_cmd;
    logic       leds_on_cmd;
    logic [5:0] led_pattern;
    logic       frame_done;

    modport source (output valid, relay_video_on, video_trigger, pi_power_off,
                    heartbeat_led, leds_off_cmd, leds_on_cmd, led_pattern,
                    frame_done, input ready);
    modport sink   (input valid, relay_video_on, video_trigger, pi_power_off,
                    heartbeat_led, leds_off_cmd, leds_on_cmd, led_pattern,
                    frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfvs_ram.sv =====
// ============================================================================
// bfvs_ram
// Generic RAM, one write port and one registered read port.
// ============================================================================
`default_nettype none

module bfvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end
endmodule

`default_nettype wire

// ===== rtl/core/bfvs_ctrl.sv =====
// ============================================================================
// bfvs_ctrl
// Sequencer: accept, frame judge, custom pattern compare, result hand-off.
// ============================================================================
`default_nettype none

module bfvs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire bfvs_pkg::ctl_status_t st,
    output bfvs_pkg::ctl_cmd_t        cmd
);
    import bfvs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_JUDGE  = 3'd1;
    localparam logic [2:0] S_CK_RD  = 3'd2;
    localparam logic [2:0] S_CK_CMP = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = st.complete ? S_JUDGE : S_OUT;
                end
            end
            S_JUDGE:
            begin
                cmd.judge  = 1'b1;
                state_next = st.custom ? S_CK_RD : S_OUT;
            end
            S_CK_RD:
            begin
                state_next = S_CK_CMP;
            end
            S_CK_CMP:
            begin
                cmd.ck_cmp = 1'b1;
                if (!st.pair_match)
                begin
                    state_next = S_OUT;
                end
                else if (st.pair_last)
                begin
                    cmd.ck_enter = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_CK_RD;
                end
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

// ===== rtl/core/bfvs_dp.sv =====
// ============================================================================
// bfvs_dp
// Datapath: frame storage, rule decode, timers, pins and result register.
// ============================================================================
`default_nettype none

module bfvs_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bfvs_pkg::ctl_cmd_t cmd,
    output bfvs_pkg::ctl_status_t   st,
    input  wire logic               in_cmd,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               rx_error,
    input  wire logic               line_idle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              out_pins,
    output logic                    out_off,
    output logic                    out_on,
    output logic [5:0]              out_pattern,
    output logic                    out_done
);
    import bfvs_pkg::*;

    logic [POS_W-1:0] wp_reg, wp_next, wp_inc;
    logic [7:0]  src_reg, src_next, ns;
    logic [7:0]  set_reg, set_next;
    logic [7:0]  cp0_reg, cp0_next;
    logic [7:0]  cp_hi_reg [1:CUSTOM_BYTES-1];
    logic [7:0]  cp_hi_next [1:CUSTOM_BYTES-1];
    logic [7:0]  cp [CUSTOM_BYTES];
    logic [9:0]  hb_reg, hb_next, hb_inc;
    logic [8:0]  idle_reg, idle_next;
    logic [9:0]  lc_reg, lc_next;
    logic [5:0]  lq_reg, lq_next;
    logic [9:0]  lqt_reg, lqt_next;
    logic [10:0] boot_reg, boot_next;
    logic        seen_reg, seen_next;
    logic [3:0]  pins_reg, pins_next;
    logic        off_reg, off_next, on_reg, on_next, done_reg, done_next;
    logic [5:0]  pat_reg, pat_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic        ov_reg, ov_next;
    logic [3:0]  opins_reg;
    logic        ooff_reg, oon_reg, odone_reg;
    logic [5:0]  opat_reg;
    logic [7:0]  sh_reg [SHADOW_N];
    logic [7:0]  b [SHADOW_N];
    logic        byte_we, led_ok, fob_ok, set_ok;
    logic [3:0]  act;
    logic [7:0]  ck_idx, ck_val, rd_data;

    always_comb
    begin
        for (int i = 0; i < SHADOW_N; i++)
        begin
            b[i] = sh_reg[i];
        end
        cp[0] = cp0_reg;
        for (int i = 1; i < CUSTOM_BYTES; i++)
        begin
            cp[i] = cp_hi_reg[i];
        end
    end

    assign wp_inc  = wp_reg + POS_W'(1);
    assign byte_we = cmd.accept && !in_cmd && !rx_error && (wp_reg < POS_W'(BUF_DEPTH));

    // Frame completes once the length byte plus two reaches the count
    assign st.complete = byte_we && (wp_inc >= POS_W'(5)) &&
                         ({1'b0, b[1]} + 9'd2 == 9'(wp_inc));

    // Pick the pair under test
    always_comb
    begin
        ck_idx = cp[0];
        ck_val = cp[1];
        for (int k = 0; k < NPAIR; k++)
        begin
            if (pair_reg == PAIR_W'(k))
            begin
                ck_idx = cp[2*k];
                ck_val = cp[2*k+1];
            end
        end
    end

    bfvs_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
        .clk     (clk),
        .wr_en   (byte_we),
        .wr_addr (wp_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_addr (ck_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign st.pair_match = (ck_idx < IDX_LIMIT) && (rd_data == ck_val);
    assign st.pair_last  = (pair_reg == PAIR_W'(NPAIR - 1));
    assign st.custom     = (act == ACT_CUSTOM);
    assign st.out_free   = !ov_reg || out_ready;

    assign fob_ok = ((b[1] ^ b[2] ^ b[3] ^ b[4]) == b[5]);
    assign set_ok = ((b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4]) == b[5]);

    // Rule decode, first match wins
    always_comb
    begin
        act = ACT_NONE;
        if (wp_reg == POS_W'(5) && b[0] == 8'h50 && b[2] == 8'hC8 && b[3] == 8'h01 &&
            b[4] == 8'h9A)
        begin
            act = ACT_NONE;
        end
        else if (wp_reg == POS_W'(6) && b[0] == 8'h50 && b[2] == 8'hC8 &&
                 b[3] == 8'h3B && b[4] == 8'h80 && b[5] == 8'h27)
        begin
            act = ACT_NONE;
        end
        else if (wp_reg == POS_W'(6) && b[0] == 8'hF0 && b[2] == 8'hFF &&
                 b[3] == 8'h48 && b[4] == 8'h08 && b[5] == 8'h4B &&
                 !set_reg[SET_NO_PHONE])
        begin
            act = ACT_PHONE;
        end
        else if (wp_reg == POS_W'(6) && b[0] == 8'h00 && b[2] == 8'hBF && b[3] == 8'h72)
        begin
            act = ACT_FOB;
        end
        else if (wp_reg == POS_W'(12) && b[0] == 8'h80 && b[2] == 8'hBF &&
                 b[3] == 8'h13 && !set_reg[SET_NO_CAMERA])
        begin
            act = ACT_CAMERA;
        end
        else if (b[0] == 8'hD7 && b[2] == 8'hD8)
        begin
            act = ACT_SETWR;
        end
        else if ((wp_reg == POS_W'(20) && b[0] == 8'h68 && b[6] == 8'h43 &&
                  b[13] == 8'h34 && b[19] == 8'h4C) ||
                 (wp_reg >= POS_W'(16) && b[0] == 8'h68 && b[6] == 8'h54 &&
                  b[7] == 8'h52 && b[8] == 8'h20 && b[9] == 8'h30 && b[10] == 8'h34) ||
                 (wp_reg == POS_W'(25) && b[0] == 8'h68 && b[15] == 8'h43 &&
                  b[16] == 8'h44 && b[18] == 8'h31 && b[20] == 8'h30 &&
                  b[21] == 8'h34 && b[24] == 8'h25))
        begin
            act = ACT_ENTER;
        end
        else if (wp_reg == POS_W'(6) && !set_reg[SET_NO_CDC])
        begin
            if (b[0] == 8'hF0 && b[3] == 8'h48)
            begin
                if (b[4] == 8'h21 || b[4] == 8'h23 || b[4] == 8'h31 || b[4] == 8'h34)
                begin
                    act = ACT_LEAVE;
                end
            end
            else if (b[0] == 8'h68 && b[2] == 8'h3B && b[3] == 8'h46 &&
                     b[4] == 8'h02 && b[5] == 8'h13)
            begin
                act = ACT_LEAVE;
            end
        end
        else if (cp[0] != 8'h00 && b[0] == 8'h68 && b[2] == 8'h3B)
        begin
            act = ACT_CUSTOM;
        end
    end

    assign led_ok = line_idle && (wp_reg == '0);
    assign hb_inc = hb_reg + 10'd1;
    assign ns     = (src_reg >= 8'd2) ? 8'd0 : src_reg + 8'd1;

    always_comb
    begin
        wp_next   = wp_reg;
        src_next  = src_reg;
        set_next  = set_reg;
        cp0_next  = cp0_reg;
        for (int i = 1; i < CUSTOM_BYTES; i++)
        begin
            cp_hi_next[i] = cp_hi_reg[i];
        end
        hb_next   = hb_reg;
        idle_next = idle_reg;
        lc_next   = lc_reg;
        lq_next   = lq_reg;
        lqt_next  = lqt_reg;
        boot_next = boot_reg;
        seen_next = seen_reg;
        pins_next = pins_reg;
        off_next  = off_reg;
        on_next   = on_reg;
        pat_next  = pat_reg;
        done_next = done_reg;
        pair_next = pair_reg;

        if (cmd.accept)
        begin
            off_next  = 1'b0;
            on_next   = 1'b0;
            pat_next  = '0;
            done_next = 1'b0;
            if (!in_cmd)
            begin
                if (byte_we)
                begin
                    wp_next = wp_inc;
                end
            end
            else
            begin
                pins_next[PIN_HB] = (hb_inc == 10'd1) || (!seen_reg && hb_inc == 10'd30);
                if (idle_reg >= IDLE_LIMIT)
                begin
                    idle_next = IDLE_LIMIT;
                    hb_next   = (hb_inc >= HB_IDLE_WRAP) ? 10'd0 : hb_inc;
                    if (!set_reg[SET_NO_IDLE])
                    begin
                        pins_next[PIN_PWROFF] = 1'b1;
                    end
                end
                else
                begin
                    if (hb_inc >= HB_SECOND)
                    begin
                        hb_next   = 10'd0;
                        idle_next = idle_reg + 9'd1;
                    end
                    else
                    begin
                        hb_next = hb_inc;
                    end
                    pins_next[PIN_PWROFF] = 1'b0;
                end
                if (lc_reg == 10'd1 && led_ok)
                begin
                    lc_next  = 10'd0;
                    off_next = 1'b1;
                end
                else if (lc_reg > 10'd1)
                begin
                    lc_next = lc_reg - 10'd1;
                end
                if (lq_reg != 6'd0 && led_ok)
                begin
                    lc_next  = lqt_reg;
                    on_next  = 1'b1;
                    pat_next = lq_reg;
                    lq_next  = 6'd0;
                end
                if (boot_reg != 11'd0)
                begin
                    boot_next = boot_reg - 11'd1;
                end
                wp_next = '0;
            end
        end

        if (cmd.judge)
        begin
            done_next = 1'b1;
            wp_next   = '0;
            idle_next = 9'd0;
            seen_next = 1'b1;
            pair_next = '0;
            case (act)
                ACT_PHONE:
                begin
                    lqt_next  = LED_T_PHONE;
                    src_next  = ns;
                    lq_next   = (ns == 8'd0) ? LED_SRC0 : (ns == 8'd1) ? LED_SRC1 : LED_SRC2;
                    pins_next = drive_source(pins_reg, ns);
                end
                ACT_FOB:
                begin
                    if (fob_ok)
                    begin
                        if (b[4][6])
                        begin
                            lq_next   = LED_SRC2;
                            lqt_next  = LED_T_BOOT;
                            boot_next = BOOT_TICKS;
                        end
                        else if (boot_reg != 11'd0 && boot_reg < BOOT_WINDOW)
                        begin
                            lq_next  = LED_ALL;
                            lqt_next = LED_T_FOB;
                        end
                    end
                end
                ACT_CAMERA:
                begin
                    pins_next = drive_source(pins_reg,
                                             (b[5][7:4] == 4'd1) ? 8'd2 : src_reg);
                end
                ACT_SETWR:
                begin
                    if (wp_reg == POS_W'(6))
                    begin
                        if (set_ok)
                        begin
                            if (b[3] == 8'h70)
                            begin
                                set_next = b[4];
                            end
                            else if (b[3] == 8'h71)
                            begin
                                src_next  = b[4];
                                pins_next = drive_source(pins_reg, b[4]);
                            end
                        end
                    end
                    else if (wp_reg == POS_W'(17))
                    begin
                        cp0_next = b[4];
                        for (int i = 1; i < CUSTOM_BYTES; i++)
                        begin
                            cp_hi_next[i] = b[4+i];
                        end
                    end
                end
                ACT_ENTER:
                begin
                    if (!set_reg[SET_NO_CDC])
                    begin
                        src_next  = 8'd1;
                        pins_next = drive_source(pins_reg, 8'd1);
                    end
                end
                ACT_LEAVE:
                begin
                    src_next  = 8'd0;
                    pins_next = drive_source(pins_reg, 8'd0);
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.ck_cmp)
        begin
            pair_next = pair_reg + PAIR_W'(1);
        end

        if (cmd.ck_enter && !set_reg[SET_NO_CDC])
        begin
            src_next  = 8'd1;
            pins_next = drive_source(pins_reg, 8'd1);
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            src_reg  <= '0;
            set_reg  <= '0;
            cp0_reg  <= '0;
            hb_reg   <= '0;
            idle_reg <= '0;
            lc_reg   <= '0;
            lq_reg   <= '0;
            lqt_reg  <= '0;
            boot_reg <= '0;
            seen_reg <= 1'b0;
            pins_reg <= '0;
            off_reg  <= 1'b0;
            on_reg   <= 1'b0;
            pat_reg  <= '0;
            done_reg <= 1'b0;
            pair_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            wp_reg   <= wp_next;
            src_reg  <= src_next;
            set_reg  <= set_next;
            cp0_reg  <= cp0_next;
            hb_reg   <= hb_next;
            idle_reg <= idle_next;
            lc_reg   <= lc_next;
            lq_reg   <= lq_next;
            lqt_reg  <= lqt_next;
            boot_reg <= boot_next;
            seen_reg <= seen_next;
            pins_reg <= pins_next;
            off_reg  <= off_next;
            on_reg   <= on_next;
            pat_reg  <= pat_next;
            done_reg <= done_next;
            pair_reg <= pair_next;
            ov_reg   <= ov_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 1; i < CUSTOM_BYTES; i++)
        begin
            cp_hi_reg[i] <= cp_hi_next[i];
        end
        if (byte_we && wp_reg < POS_W'(SHADOW_N))
        begin
            sh_reg[wp_reg[SH_W-1:0]] <= rx_byte;
        end
        if (cmd.load_out)
        begin
            opins_reg <= pins_reg;
            ooff_reg  <= off_reg;
            oon_reg   <= on_reg;
            opat_reg  <= pat_reg;
            odone_reg <= done_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign out_pins    = opins_reg;
    assign out_off     = ooff_reg;
    assign out_on      = oon_reg;
    assign out_pattern = opat_reg;
    assign out_done    = odone_reg;
endmodule

`default_nettype wire

// ===== rtl/core/bus_frame_video_switch_controller_unit.sv =====
// ============================================================================
// bus_frame_video_switch_controller_unit
// Bus frame collector and video switch controller, top level.
// ============================================================================
// Each input item is a received bus byte or a timer tick, and each gives
// exactly one result: the relay, trigger, power and heartbeat levels after
// the item, plus the LED command flags and a frame-done flag. A byte or tick
// passes from the accept state to the hand-off state; a byte that completes
// a frame also passes the judge state, and a frame sent to the stored
// custom pattern check then reads and compares its index/value pairs in
// turn through the single read port of the frame buffer RAM. A new item
// is taken only after the previous result has been placed in the output
// register, which then holds it until the sink takes the transfer.
// ============================================================================
`default_nettype none

module bus_frame_video_switch_controller_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bfvs_in_if.sink    din,
    bfvs_out_if.source dout
);
    import bfvs_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t st;
    logic [3:0]  pins;

    // Sequencer: steps through accept, judge, pattern compare, hand-off
    bfvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: buffer, rules, timers and output register
    bfvs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_cmd      (din.cmd),
        .rx_byte     (din.rx_byte),
        .rx_error    (din.rx_error),
        .line_idle   (din.line_idle),
        .out_valid   (dout.valid),
        .out_ready   (dout.ready),
        .out_pins    (pins),
        .out_off     (dout.leds_off_cmd),
        .out_on      (dout.leds_on_cmd),
        .out_pattern (dout.led_pattern),
        .out_done    (dout.frame_done)
    );

    // Break out the pin levels
    assign dout.relay_video_on = pins[PIN_RELAY];
    assign dout.video_trigger  = pins[PIN_TRIG];
    assign dout.pi_power_off   = pins[PIN_PWROFF];
    assign dout.heartbeat_led  = pins[PIN_HB];
endmodule

`default_nettype wire

// ===== rtl/core/bfvs_checker.sv =====
// ============================================================================
// bfvs_checker
// Port-level checks on the result channel of the top level.
// ============================================================================
`default_nettype none

module bfvs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       leds_off_cmd,
    input wire logic       leds_on_cmd,
    input wire logic [5:0] led_pattern,
    input wire logic       frame_done
);
    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(led_pattern))
        else $error("result dropped or changed while stalled");

    // A frame result never carries LED commands
    a_done_no_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !leds_on_cmd && !leds_off_cmd)
        else $error("LED command on a frame result");

    // Pattern is zero without a pattern command
    a_pat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !leds_on_cmd |-> led_pattern == 6'd0)
        else $error("pattern without command");

    // Queued patterns are never empty
    a_pat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && leds_on_cmd |-> led_pattern != 6'd0)
        else $error("empty pattern command");
endmodule

bind bus_frame_video_switch_controller_unit bfvs_checker u_bfvs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .leds_off_cmd (dout.leds_off_cmd),
    .leds_on_cmd  (dout.leds_on_cmd),
    .led_pattern  (dout.led_pattern),
    .frame_done   (dout.frame_done)
);

`default_nettype wire
